@@ rtl/core/sdl_pkg.sv @@
// Shared types and constants for the sorted deque list engine.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package sdl_pkg;

  localparam int VALUE_W = 32;
  localparam int CNT_W   = 5;

  // Request codes as they arrive on the input channel
  localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [2:0] FUNC_INSERT     = 3'd2;
  localparam logic [2:0] FUNC_POP_FRONT  = 3'd3;
  localparam logic [2:0] FUNC_POP_BACK   = 3'd4;
  localparam logic [2:0] FUNC_REMOVE     = 3'd5;
  localparam logic [2:0] FUNC_CONTAINS   = 3'd6;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_INSERT,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_REMOVE,
    OP_CONTAINS,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ES_IDLE,
    ES_EXEC,
    ES_SCAN,
    ES_FETCH,
    ES_DONE
  } eng_state_t;

  typedef struct packed {
    logic [2:0]                func;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic                      found;
    logic [CNT_W-1:0]          removed_count;
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] back_value;
    logic [CNT_W-1:0]          entry_count;
  } out_item_t;

  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

endpackage

@@ rtl/core/sdl_front.sv @@
// Front end: accepts requests, decodes the request code into an operation
// and parks them in a two-entry command queue. Depends on sdl_pkg.
`timescale 1ns / 1ps

module sdl_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  sdl_pkg::in_item_t in_data,
  output logic              cmd_vld,
  input  logic              cmd_rdy,
  output sdl_pkg::cmd_t     cmd
);

  sdl_pkg::cmd_t q_r [2];
  sdl_pkg::cmd_t dec_cmd;
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push_ok, pop_ok;

  // Classify the request
  always_comb begin
    dec_cmd.value = in_data.value;
    unique case (in_data.func)
      sdl_pkg::FUNC_PUSH_FRONT: dec_cmd.op = sdl_pkg::OP_PUSH_FRONT;
      sdl_pkg::FUNC_PUSH_BACK:  dec_cmd.op = sdl_pkg::OP_PUSH_BACK;
      sdl_pkg::FUNC_INSERT:     dec_cmd.op = sdl_pkg::OP_INSERT;
      sdl_pkg::FUNC_POP_FRONT:  dec_cmd.op = sdl_pkg::OP_POP_FRONT;
      sdl_pkg::FUNC_POP_BACK:   dec_cmd.op = sdl_pkg::OP_POP_BACK;
      sdl_pkg::FUNC_REMOVE:     dec_cmd.op = sdl_pkg::OP_REMOVE;
      sdl_pkg::FUNC_CONTAINS:   dec_cmd.op = sdl_pkg::OP_CONTAINS;
      default:                  dec_cmd.op = sdl_pkg::OP_NOP;
    endcase
  end

  assign in_full = (cnt_r == 2'd2);
  assign cmd_vld = (cnt_r != 2'd0);
  assign cmd     = q_r[rp_r];
  assign push_ok = in_push && !in_full;
  assign pop_ok  = cmd_vld && cmd_rdy;
  assign cnt_nxt = 2'(cnt_r + {1'b0, push_ok} - {1'b0, pop_ok});

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r] <= dec_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_r ^ push_ok;
      rp_r  <= rp_r ^ pop_ok;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ rtl/core/sdl_back.sv @@
// Back end: list storage in a circular memory, the operation sequencer that
// walks it, and the result register. Depends on sdl_pkg.
`timescale 1ns / 1ps

module sdl_back #(
  parameter int LIST_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_vld,
  output logic               cmd_rdy,
  input  sdl_pkg::cmd_t      cmd,
  output logic               out_empty,
  input  logic               out_pop,
  output sdl_pkg::out_item_t out_data
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int VW = sdl_pkg::VALUE_W;

  // Map a position in the list onto a memory address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] idx);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(idx);
    if (sum >= SW'(LIST_DEPTH)) sum = sum - SW'(LIST_DEPTH);
    return sum[AW-1:0];
  endfunction

  logic signed [VW-1:0] mem [LIST_DEPTH];

  sdl_pkg::eng_state_t state_r, state_nxt;
  sdl_pkg::cmd_t       cmd_r, cmd_nxt;
  sdl_pkg::status_t    status_r, status_nxt;
  sdl_pkg::out_item_t  out_r, out_nxt;

  logic [AW-1:0]        head_r, head_nxt, head_inc, head_dec;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        iss_r, iss_nxt;
  logic [CW-1:0]        pidx_r, pidx_nxt;
  logic [CW-1:0]        wpos_r, wpos_nxt;
  logic [CW-1:0]        rm_r, rm_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic                 found_r, found_nxt;
  logic                 ins_r, ins_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic signed [VW-1:0] front_r, front_nxt, back_r, back_nxt, hold_r, hold_nxt;
  logic signed [VW-1:0] rd_data_r, wr_data;

  logic                 rd_en, wr_en, wr_at_head;
  logic [CW-1:0]        rd_idx, wr_idx;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic                 full, empty, scan_end, slot_free, d_eq, d_lt;
  logic signed [VW-1:0] tail_val;

  assign full      = (count_r == CW'(LIST_DEPTH));
  assign empty     = (count_r == '0);
  assign scan_end  = !rd_vld_r && (iss_r == count_r);
  assign slot_free = !out_vld_r || out_pop;
  assign head_inc  = (head_r == AW'(LIST_DEPTH - 1)) ? '0 : AW'(head_r + 1'b1);
  assign head_dec  = (head_r == '0) ? AW'(LIST_DEPTH - 1) : AW'(head_r - 1'b1);
  assign d_eq      = (rd_data_r == cmd_r.value);
  assign d_lt      = ($signed(rd_data_r) < $signed(cmd_r.value));
  assign tail_val  = ins_r ? hold_r : cmd_r.value;
  assign rd_addr   = phys(head_r, rd_idx);
  assign wr_addr   = wr_at_head ? head_dec : phys(head_r, wr_idx);
  assign cmd_rdy   = (state_r == sdl_pkg::ES_IDLE);
  assign out_empty = !out_vld_r;
  assign out_data  = out_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sdl_pkg::ES_IDLE: begin
        if (cmd_vld) state_nxt = sdl_pkg::ES_EXEC;
      end
      sdl_pkg::ES_EXEC: begin
        unique case (cmd_r.op) inside
          sdl_pkg::OP_INSERT: begin
            state_nxt = full ? sdl_pkg::ES_DONE : sdl_pkg::ES_SCAN;
          end
          sdl_pkg::OP_REMOVE, sdl_pkg::OP_CONTAINS: begin
            state_nxt = sdl_pkg::ES_SCAN;
          end
          sdl_pkg::OP_POP_FRONT, sdl_pkg::OP_POP_BACK: begin
            state_nxt = (count_r > CW'(1)) ? sdl_pkg::ES_FETCH : sdl_pkg::ES_DONE;
          end
          default: state_nxt = sdl_pkg::ES_DONE;
        endcase
      end
      sdl_pkg::ES_SCAN: begin
        if (scan_end) state_nxt = sdl_pkg::ES_DONE;
      end
      sdl_pkg::ES_FETCH: state_nxt = sdl_pkg::ES_DONE;
      sdl_pkg::ES_DONE: begin
        if (slot_free) state_nxt = sdl_pkg::ES_IDLE;
      end
      default: state_nxt = sdl_pkg::ES_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    cmd_nxt     = cmd_r;
    status_nxt  = status_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    iss_nxt     = iss_r;
    pidx_nxt    = pidx_r;
    wpos_nxt    = wpos_r;
    rm_nxt      = rm_r;
    rd_vld_nxt  = 1'b0;
    found_nxt   = found_r;
    ins_nxt     = ins_r;
    front_nxt   = front_r;
    back_nxt    = back_r;
    hold_nxt    = hold_r;
    out_vld_nxt = out_vld_r && !out_pop;
    out_nxt     = out_r;
    rd_en       = 1'b0;
    rd_idx      = iss_r;
    wr_en       = 1'b0;
    wr_at_head  = 1'b0;
    wr_idx      = count_r;
    wr_data     = cmd_r.value;

    unique case (state_r)
      sdl_pkg::ES_IDLE: begin
        if (cmd_vld) begin
          cmd_nxt    = cmd;
          status_nxt = sdl_pkg::ST_OK;
          found_nxt  = 1'b0;
          rm_nxt     = '0;
          iss_nxt    = '0;
          wpos_nxt   = '0;
          ins_nxt    = 1'b0;
        end
      end

      sdl_pkg::ES_EXEC: begin
        unique case (cmd_r.op) inside
          sdl_pkg::OP_PUSH_FRONT, sdl_pkg::OP_PUSH_BACK: begin
            if (full) begin
              status_nxt = sdl_pkg::ST_FULL;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + CW'(1);
              if (cmd_r.op == sdl_pkg::OP_PUSH_FRONT) begin
                wr_at_head = 1'b1;
                head_nxt   = head_dec;
                front_nxt  = cmd_r.value;
                if (empty) back_nxt = cmd_r.value;
              end else begin
                back_nxt = cmd_r.value;
                if (empty) front_nxt = cmd_r.value;
              end
            end
          end
          sdl_pkg::OP_INSERT: begin
            if (full) status_nxt = sdl_pkg::ST_FULL;
          end
          sdl_pkg::OP_POP_FRONT, sdl_pkg::OP_POP_BACK: begin
            if (empty) begin
              status_nxt = sdl_pkg::ST_EMPTY;
            end else begin
              count_nxt = count_r - CW'(1);
              rm_nxt    = CW'(1);
              rd_en     = (count_r > CW'(1));
              if (cmd_r.op == sdl_pkg::OP_POP_FRONT) begin
                head_nxt = head_inc;
                rd_idx   = CW'(1);
              end else begin
                rd_idx   = count_r - CW'(2);
              end
            end
          end
          default: begin
          end
        endcase
      end

      sdl_pkg::ES_SCAN: begin
        // Issue one read per cycle
        if (iss_r < count_r) begin
          rd_en      = 1'b1;
          rd_idx     = iss_r;
          iss_nxt    = iss_r + CW'(1);
          pidx_nxt   = iss_r;
          rd_vld_nxt = 1'b1;
        end
        // Handle the entry read in the previous cycle
        if (rd_vld_r) begin
          unique case (cmd_r.op) inside
            sdl_pkg::OP_CONTAINS: begin
              if (d_eq) found_nxt = 1'b1;
            end
            sdl_pkg::OP_REMOVE: begin
              if (d_eq) begin
                rm_nxt = rm_r + CW'(1);
              end else begin
                wr_en    = 1'b1;
                wr_idx   = wpos_r;
                wr_data  = rd_data_r;
                wpos_nxt = wpos_r + CW'(1);
                back_nxt = rd_data_r;
                if (wpos_r == '0) front_nxt = rd_data_r;
              end
            end
            sdl_pkg::OP_INSERT: begin
              if (ins_r) begin
                wr_en    = 1'b1;
                wr_idx   = pidx_r;
                wr_data  = hold_r;
                hold_nxt = rd_data_r;
              end else if (!d_lt) begin
                wr_en    = 1'b1;
                wr_idx   = pidx_r;
                wr_data  = cmd_r.value;
                hold_nxt = rd_data_r;
                ins_nxt  = 1'b1;
                if (pidx_r == '0) front_nxt = cmd_r.value;
              end
            end
            default: begin
            end
          endcase
        end
        // Close out the pass
        if (scan_end) begin
          if (cmd_r.op == sdl_pkg::OP_REMOVE) begin
            count_nxt = wpos_r;
          end else if (cmd_r.op == sdl_pkg::OP_INSERT) begin
            wr_en     = 1'b1;
            wr_idx    = count_r;
            wr_data   = tail_val;
            back_nxt  = tail_val;
            count_nxt = count_r + CW'(1);
            if (empty) front_nxt = cmd_r.value;
          end
        end
      end

      sdl_pkg::ES_FETCH: begin
        if (cmd_r.op == sdl_pkg::OP_POP_FRONT) front_nxt = rd_data_r;
        else                                    back_nxt  = rd_data_r;
      end

      sdl_pkg::ES_DONE: begin
        if (slot_free) begin
          out_vld_nxt           = 1'b1;
          out_nxt.status        = status_r;
          out_nxt.found         = found_r;
          out_nxt.removed_count = sdl_pkg::CNT_W'(rm_r);
          out_nxt.front_value   = empty ? '0 : front_r;
          out_nxt.back_value    = empty ? '0 : back_r;
          out_nxt.entry_count   = sdl_pkg::CNT_W'(count_r);
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    status_r <= status_nxt;
    iss_r    <= iss_nxt;
    pidx_r   <= pidx_nxt;
    wpos_r   <= wpos_nxt;
    rm_r     <= rm_nxt;
    found_r  <= found_nxt;
    ins_r    <= ins_nxt;
    front_r  <= front_nxt;
    back_r   <= back_nxt;
    hold_r   <= hold_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sdl_pkg::ES_IDLE;
      head_r    <= '0;
      count_r   <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

@@ rtl/core/sorted_deque_list_engine.sv @@
// Push, pop, unknown codes and refused requests complete without a scan; a pop that leaves
//   entries also fetches the new end; insert, remove-all and contains walk the whole list.
// The engine executes one request at a time while the front queue takes further ones; a scan
//   uses the single read port of the list memory, which it walks one entry per cycle.
// Reset (synchronous, rst_n low): list empty, queues empty; memory contents are not cleared.
// Top level of the sorted deque list engine; depends on sdl_pkg, sdl_front and sdl_back.
`timescale 1ns / 1ps

module sorted_deque_list_engine #(
  parameter int LIST_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  sdl_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output sdl_pkg::out_item_t out_data
);

  // Command queue between decode and execution
  sdl_pkg::cmd_t cmd;
  logic          cmd_vld;
  logic          cmd_rdy;

  // Front: take items and classify them; holds up to two decoded commands
  sdl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .cmd_vld (cmd_vld),
    .cmd_rdy (cmd_rdy),
    .cmd     (cmd)
  );

  // Back: execute one command at a time against the list memory and
  // hold the result in an output register until it is popped
  sdl_back #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_vld   (cmd_vld),
    .cmd_rdy   (cmd_rdy),
    .cmd       (cmd),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // The engine is not ready again in the cycle after it takes a command
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_vld && cmd_rdy |=> !cmd_rdy)
    else $error("engine took a command back to back");

  // A refused push or insert always reports a full list and no removals
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.status == sdl_pkg::ST_FULL |->
      out_data.entry_count == sdl_pkg::CNT_W'(LIST_DEPTH) && out_data.removed_count == '0)
    else $error("full status with wrong count");

  // A refused pop reports an empty list with zero ends
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.status == sdl_pkg::ST_EMPTY |->
      out_data.entry_count == '0 && out_data.front_value == '0 &&
      out_data.back_value == '0)
    else $error("empty status with nonempty view");

  // A full command queue always offers a command to the engine
  a_queue_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> cmd_vld)
    else $error("command queue full with no command offered");
`endif

endmodule
